### rtl/core/mspi_pkg.sv
// ---------------------------------------------------------------------------
// mspi_pkg
// Shared widths, constants and register indexes for the moving sphere versus
// plane intersection pipeline.
// ---------------------------------------------------------------------------
package mspi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NRM_W     = 18;
  localparam int CRD_W     = 32;
  localparam int RAD_W     = 31;
  localparam int TIME_W    = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Dot product of an 18-bit normal and 32-bit vector: 50-bit products, sum of three
  localparam int PROD_W = NRM_W + CRD_W;
  localparam int DOT_W  = PROD_W + 2;
  // Shifted dot plus offset
  localparam int DIST_W = DOT_W - FRAC_BITS + 1;
  localparam int DEN_W  = DOT_W - FRAC_BITS;
  // Numerator |s - dist| and scaled dividend
  localparam int NUM_W  = DIST_W + 1;
  localparam int DVD_W  = NUM_W + FRAC_BITS;
  // Quotient bits needed to saturate to TIME_W: TIME_W+1 bits
  localparam int QB     = TIME_W + 1;
  // Unsaturated contact coordinate: c + t*v/2^F - s*N/2^F
  localparam int PNT_W  = TIME_W + CRD_W - FRAC_BITS + 3;

  localparam logic [CFG_IDX_W-1:0] REG_NX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NZ  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFS = 2'd3;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic signed [CRD_W-1:0] ofs;
  } plane_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [CRD_W-1:0] sat32(input logic signed [PNT_W-1:0] x);
    logic signed [PNT_W-1:0] hi;
    logic signed [PNT_W-1:0] lo;
    hi = PNT_W'(signed'({1'b0, {(CRD_W-1){1'b1}}}));
    lo = -hi - PNT_W'(1);
    if (x > hi) return {1'b0, {(CRD_W-1){1'b1}}};
    if (x < lo) return {1'b1, {(CRD_W-1){1'b0}}};
    return x[CRD_W-1:0];
  endfunction

endpackage

### rtl/core/mspi_div.sv
// ---------------------------------------------------------------------------
// mspi_div
// Pipelined restoring divider, one quotient bit per stage. Returns the
// quotient saturated to TIME_W bits.
// ---------------------------------------------------------------------------
module mspi_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [mspi_pkg::DVD_W-1:0]    in_dvd,
  input  logic [mspi_pkg::DEN_W-1:0]    in_den,
  output logic                          out_vld,
  output logic [mspi_pkg::TIME_W-1:0]   out_q
);
  import mspi_pkg::*;

  localparam int REM_W = DEN_W + 1;

  // Stage k holds a remainder against the top dividend bits, the remaining
  // dividend bits, the divisor, quotient bits and an overflow flag.
  logic [QB:0]            vld_r;
  logic [REM_W-1:0]       rem_r [QB+1];
  logic [QB-1:0]          lowb_r [QB+1];
  logic [DEN_W-1:0]       den_r [QB+1];
  logic [QB-1:0]          q_r   [QB+1];
  logic [QB:0]            ovf_r;

  logic [DVD_W-QB-1:0]    hi_part;
  logic [DEN_W-1:0]       hi_ext;
  logic                   hi_ovf;
  assign hi_part = in_dvd[DVD_W-1:QB];
  assign hi_ext  = DEN_W'(hi_part);
  assign hi_ovf  = hi_ext >= in_den;

  // Load: the quotient overflows QB bits when the high part is at least den;
  // otherwise start the remainder from the high part, which is below den.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    rem_r[0]  <= hi_ovf ? '0 : REM_W'(hi_part);
    lowb_r[0] <= in_dvd[QB-1:0];
    den_r[0]  <= in_den;
    q_r[0]    <= '0;
    ovf_r[0]  <= hi_ovf;
  end

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_stage
      logic [REM_W:0]   trial;
      logic             ge;
      assign trial  = {rem_r[k], lowb_r[k][QB-1]};
      assign ge     = trial >= (REM_W+1)'(den_r[k]);
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k+1] <= 1'b0;
        end else begin
          vld_r[k+1] <= vld_r[k];
        end
        rem_r[k+1]  <= ge ? REM_W'(trial - (REM_W+1)'(den_r[k])) : REM_W'(trial);
        lowb_r[k+1] <= {lowb_r[k][QB-2:0], 1'b0};
        den_r[k+1]  <= den_r[k];
        q_r[k+1]    <= {q_r[k][QB-2:0], ge};
        ovf_r[k+1]  <= ovf_r[k];
      end
    end
  endgenerate

  assign out_vld = vld_r[QB];
  assign out_q   = (ovf_r[QB] || q_r[QB][QB-1]) ? TIME_MAX : q_r[QB][TIME_W-1:0];

endmodule

### rtl/core/moving_sphere_plane_intersect_unit.sv
// ---------------------------------------------------------------------------
// moving_sphere_plane_intersect_unit
// Moving sphere versus configured plane test, Q16.16, fully pipelined.
// ---------------------------------------------------------------------------
// One transaction is accepted every cycle (busy is never raised) and its
// result appears on out_valid after two dot-product stages, one
// classify stage, a load stage and 32 quotient-bit stages in the divider,
// and two contact-point stages; throughput is one transaction per clock.
// Results cannot be held off.
// Write the plane only while no transaction is in flight.
module moving_sphere_plane_intersect_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [mspi_pkg::CRD_W-1:0] in_center_x,
  input  logic signed [mspi_pkg::CRD_W-1:0] in_center_y,
  input  logic signed [mspi_pkg::CRD_W-1:0] in_center_z,
  input  logic [mspi_pkg::RAD_W-1:0]        in_sphere_radius,
  input  logic signed [mspi_pkg::CRD_W-1:0] in_move_x,
  input  logic signed [mspi_pkg::CRD_W-1:0] in_move_y,
  input  logic signed [mspi_pkg::CRD_W-1:0] in_move_z,
  input  logic                              cfg_we,
  input  logic [mspi_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mspi_pkg::CFG_DAT_W-1:0]    cfg_data,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [mspi_pkg::TIME_W-1:0]       out_hit_time,
  output logic signed [mspi_pkg::CRD_W-1:0] out_contact_x,
  output logic signed [mspi_pkg::CRD_W-1:0] out_contact_y,
  output logic signed [mspi_pkg::CRD_W-1:0] out_contact_z
);
  import mspi_pkg::*;

  localparam int LAT = QB + 1;

  assign busy = 1'b0;

  // Configuration registers
  plane_t pl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_r.nx  <= '0;
      pl_r.ny  <= NRM_W'(1) <<< FRAC_BITS;
      pl_r.nz  <= '0;
      pl_r.ofs <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NX:  pl_r.nx  <= cfg_data[NRM_W-1:0];
        REG_NY:  pl_r.ny  <= cfg_data[NRM_W-1:0];
        REG_NZ:  pl_r.nz  <= cfg_data[NRM_W-1:0];
        REG_OFS: pl_r.ofs <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: six products
  logic              v1_r;
  logic signed [PROD_W-1:0] pc_r [3];
  logic signed [PROD_W-1:0] pv_r [3];
  logic signed [CRD_W-1:0]  c1_r [3];
  logic signed [CRD_W-1:0]  m1_r [3];
  logic [RAD_W-1:0]         r1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    pc_r[0] <= PROD_W'(pl_r.nx) * PROD_W'(in_center_x);
    pc_r[1] <= PROD_W'(pl_r.ny) * PROD_W'(in_center_y);
    pc_r[2] <= PROD_W'(pl_r.nz) * PROD_W'(in_center_z);
    pv_r[0] <= PROD_W'(pl_r.nx) * PROD_W'(in_move_x);
    pv_r[1] <= PROD_W'(pl_r.ny) * PROD_W'(in_move_y);
    pv_r[2] <= PROD_W'(pl_r.nz) * PROD_W'(in_move_z);
    c1_r <= '{in_center_x, in_center_y, in_center_z};
    m1_r <= '{in_move_x, in_move_y, in_move_z};
    r1_r <= in_sphere_radius;
  end

  // Stage 2: sums, distance and denominator
  logic                     v2_r;
  logic signed [DIST_W-1:0] dist_r;
  logic signed [DEN_W-1:0]  den2_r;
  logic signed [CRD_W-1:0]  c2_r [3];
  logic signed [CRD_W-1:0]  m2_r [3];
  logic [RAD_W-1:0]         r2_r;
  logic signed [DOT_W-1:0]  dc, dv;
  assign dc = DOT_W'(pc_r[0]) + DOT_W'(pc_r[1]) + DOT_W'(pc_r[2]);
  assign dv = DOT_W'(pv_r[0]) + DOT_W'(pv_r[1]) + DOT_W'(pv_r[2]);
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    dist_r <= DIST_W'(dc >>> FRAC_BITS) + DIST_W'(pl_r.ofs);
    den2_r <= DEN_W'(dv >>> FRAC_BITS);
    c2_r <= c1_r;
    m2_r <= m1_r;
    r2_r <= r1_r;
  end

  // Stage 3: classify and build the dividend
  logic signed [DIST_W:0] rr, nr;
  logic ovl, front, bad;
  logic signed [NUM_W-1:0] num;
  assign rr    = (DIST_W+1)'(signed'({1'b0, r2_r}));
  assign nr    = -rr;
  assign ovl   = ((DIST_W+1)'(dist_r) <= rr) && ((DIST_W+1)'(dist_r) >= nr);
  assign front = dist_r > 0;
  assign bad   = (den2_r == 0) || ((den2_r > 0) == front);
  assign num   = front ? (NUM_W'(dist_r) - NUM_W'(rr)) : (NUM_W'(nr) - NUM_W'(dist_r));

  logic                    v3_r;
  logic                    ovl3_r, mov3_r, front3_r;
  logic [DVD_W-1:0]        dvd3_r;
  logic [DEN_W-1:0]        den3_r;
  logic signed [CRD_W-1:0] c3_r [3];
  logic signed [CRD_W-1:0] m3_r [3];
  logic [RAD_W-1:0]        r3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    ovl3_r   <= ovl;
    mov3_r   <= !ovl && !bad;
    front3_r <= front;
    dvd3_r   <= DVD_W'(unsigned'(num)) << FRAC_BITS;
    den3_r   <= (den2_r < 0) ? DEN_W'(-den2_r) : DEN_W'(den2_r);
    c3_r <= c2_r;
    m3_r <= m2_r;
    r3_r <= r2_r;
  end

  logic             dv_vld;
  logic [TIME_W-1:0] dq;
  mspi_div u_div (
    .clk(clk), .rst_n(rst_n), .in_vld(v3_r),
    .in_dvd(dvd3_r), .in_den(mov3_r ? den3_r : DEN_W'(1)),
    .out_vld(dv_vld), .out_q(dq)
  );

  // Delay side-band alongside the divider
  logic                    ovl_d [1:LAT];
  logic                    mov_d [1:LAT];
  logic                    fr_d  [1:LAT];
  logic signed [CRD_W-1:0] c_d [1:LAT][3];
  logic signed [CRD_W-1:0] m_d [1:LAT][3];
  logic [RAD_W-1:0]        r_d [1:LAT];
  genvar g;
  generate
    for (g = 1; g <= LAT; g++) begin : g_dly
      if (g == 1) begin : g_head
        always_ff @(posedge clk) begin
          ovl_d[1] <= ovl3_r; mov_d[1] <= mov3_r; fr_d[1] <= front3_r;
          c_d[1] <= c3_r; m_d[1] <= m3_r; r_d[1] <= r3_r;
        end
      end else begin : g_body
        always_ff @(posedge clk) begin
          ovl_d[g] <= ovl_d[g-1]; mov_d[g] <= mov_d[g-1]; fr_d[g] <= fr_d[g-1];
          c_d[g] <= c_d[g-1]; m_d[g] <= m_d[g-1]; r_d[g] <= r_d[g-1];
        end
      end
    end
  endgenerate

  // Contact stage A: t*v and s*N products
  localparam int TV_W = TIME_W + 1 + CRD_W;
  localparam int SN_W = RAD_W + 1 + NRM_W;
  logic [TIME_W-1:0]       t_ov;
  logic signed [TIME_W:0]  ts;
  logic signed [RAD_W:0]   ss;
  assign t_ov = mov_d[LAT] ? dq : '0;
  assign ts   = signed'({1'b0, t_ov});
  assign ss   = fr_d[LAT] ? signed'({1'b0, r_d[LAT]}) : -signed'({1'b0, r_d[LAT]});

  logic                    va_r, hita_r, ovla_r;
  logic [TIME_W-1:0]       ta_r;
  logic signed [TV_W-1:0]  tv_r [3];
  logic signed [SN_W-1:0]  sn_r [3];
  logic signed [CRD_W-1:0] ca_r [3];
  logic signed [NRM_W-1:0] nn [3];
  assign nn = '{pl_r.nx, pl_r.ny, pl_r.nz};
  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= dv_vld;
    hita_r <= mov_d[LAT];
    ovla_r <= ovl_d[LAT];
    ta_r   <= t_ov;
    ca_r   <= c_d[LAT];
    for (int i = 0; i < 3; i++) begin
      tv_r[i] <= TV_W'(ts) * TV_W'(m_d[LAT][i]);
      sn_r[i] <= SN_W'(ss) * SN_W'(nn[i]);
    end
  end

  // Contact stage B: sum and saturate
  logic signed [PNT_W-1:0] p [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = PNT_W'(ca_r[i]) + PNT_W'(tv_r[i] >>> FRAC_BITS)
           - PNT_W'(sn_r[i] >>> FRAC_BITS);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= va_r;
    out_hit      <= ovla_r || hita_r;
    out_hit_time <= hita_r ? ta_r : '0;
    out_contact_x <= ovla_r ? ca_r[0] : (hita_r ? sat32(p[0]) : '0);
    out_contact_y <= ovla_r ? ca_r[1] : (hita_r ? sat32(p[1]) : '0);
    out_contact_z <= ovla_r ? ca_r[2] : (hita_r ? sat32(p[2]) : '0);
  end

  // Checks
  a_time_only_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_time == '0) else $error("time without hit");
  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> $past(dv_vld)) else $error("divider misaligned");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> !(ovla_r && hita_r)) else $error("overlap and moving both set");

endmodule

### verif/tb_moving_sphere_plane_intersect_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_moving_sphere_plane_intersect_unit
// Drives sphere queries against a configured plane, takes hit, time and contact
// point from a table or from 64-bit integer math, checks every result in order.
// ---------------------------------------------------------------------------
module tb_moving_sphere_plane_intersect_unit;
  import mspi_pkg::*;

  localparam int   CLK_HALF   = 10;
  localparam int   DRAIN_CYC  = 60;
  localparam int   CYCLE_MAX  = 200000;
  localparam int   RAND_ITEMS = 1600;
  localparam int   PHASES     = 8;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] SMIN = 32'h8000_0000;
  localparam logic [31:0] SMAX = 32'h7fff_ffff;
  localparam logic [30:0] RMAX = 31'h7fff_ffff;

  typedef struct packed {
    logic [31:0] cx, cy, cz;
    logic [30:0] rad;
    logic [31:0] vx, vy, vz;
  } query_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] t;
    logic [31:0] px, py, pz;
  } contact_t;

  typedef struct packed {
    query_t   q;
    logic     typed;
    contact_t exp;
  } row_t;

  localparam contact_t NO_HIT = '0;
  localparam int       NROWS  = 13;

  // Directed rows, taken under the reset plane y = 0
  row_t dir_tab [NROWS] = '{
    // sphere at the origin with zero radius touches
    '{'{32'd0, 32'd0, 32'd0, 31'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
      '{1'b1, 31'd0, 32'd0, 32'd0, 32'd0}},
    // falling onto the plane from y = 10
    '{'{32'd0, 10*ONE, 32'd0, ONE[30:0], 32'd0, -ONE, 32'd0}, 1'b1,
      '{1'b1, 9*ONE[30:0], 32'd0, 32'd0, 32'd0}},
    // moving away
    '{'{32'd0, 10*ONE, 32'd0, ONE[30:0], 32'd0, ONE, 32'd0}, 1'b1, NO_HIT},
    // moving parallel
    '{'{32'd0, 10*ONE, 32'd0, ONE[30:0], ONE, 32'd0, ONE}, 1'b1, NO_HIT},
    // toward the plane by the smallest step, time saturates
    '{'{32'd0, -10*ONE, 32'd0, ONE[30:0], 32'd0, 32'd1, 32'd0}, 1'b0, NO_HIT},
    // touching exactly at |dist| == r
    '{'{32'd0, ONE, 32'd0, ONE[30:0], 32'd0, 32'd0, 32'd0}, 1'b1,
      '{1'b1, 31'd0, 32'd0, ONE, 32'd0}},
    // behind the plane moving forward
    '{'{32'd0, -5*ONE, 32'd0, ONE[30:0], 32'd0, ONE, 32'd0}, 1'b1,
      '{1'b1, 4*ONE[30:0], 32'd0, 32'd0, 32'd0}},
    // largest radius with its center on the plane overlaps
    '{'{SMAX, 32'd0, SMIN, RMAX, SMIN, SMAX, SMIN}, 1'b1,
      '{1'b1, 31'd0, SMAX, 32'd0, SMIN}},
    // extreme values, some where the time saturates
    '{'{32'd0, SMAX, 32'd0, 31'd0, 32'hffff_ffff, 32'hffff_ffff, 32'd0}, 1'b0, NO_HIT},
    '{'{SMIN, SMIN, SMIN, 31'd0, SMAX, SMAX, SMAX}, 1'b0, NO_HIT},
    '{'{SMAX, SMAX, SMAX, 31'd1, SMIN, SMIN, SMIN}, 1'b0, NO_HIT},
    '{'{SMIN, -3*ONE, SMAX, 31'h0000_8000, SMAX, 32'd3, SMIN}, 1'b0, NO_HIT},
    '{'{32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f, 31'h2aaa_5555,
        32'hf0f0_f0f0, 32'h5555_aaaa, 32'haaaa_5555}, 1'b0, NO_HIT}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [CRD_W-1:0] in_center_x, in_center_y, in_center_z;
  logic [RAD_W-1:0]        in_sphere_radius;
  logic signed [CRD_W-1:0] in_move_x, in_move_y, in_move_z;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_idx;
  logic [CFG_DAT_W-1:0]    cfg_data;
  logic                    out_valid;
  logic                    out_hit;
  logic [TIME_W-1:0]       out_hit_time;
  logic signed [CRD_W-1:0] out_contact_x, out_contact_y, out_contact_z;

  // Plane as the testbench holds it
  logic signed [NRM_W-1:0] pl_nx, pl_ny, pl_nz;
  logic signed [CRD_W-1:0] pl_ofs;

  contact_t contacts_due [$];
  int       n_errors;
  int       cycle_cnt;

  moving_sphere_plane_intersect_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_center_z     (in_center_z),
    .in_sphere_radius(in_sphere_radius),
    .in_move_x       (in_move_x),
    .in_move_y       (in_move_y),
    .in_move_z       (in_move_z),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_hit_time    (out_hit_time),
    .out_contact_x   (out_contact_x),
    .out_contact_y   (out_contact_y),
    .out_contact_z   (out_contact_z)
  );

  always #CLK_HALF clk = ~clk;

  // Work out hit, time and contact point for one query against the held plane
  function automatic contact_t sweep_sphere(query_t q);
    longint   c [3];
    longint   v [3];
    longint   n [3];
    longint   r, sdist, denom, s, num, den, quo, t, p;
    contact_t res;
    c[0] = longint'(signed'(q.cx));
    c[1] = longint'(signed'(q.cy));
    c[2] = longint'(signed'(q.cz));
    v[0] = longint'(signed'(q.vx));
    v[1] = longint'(signed'(q.vy));
    v[2] = longint'(signed'(q.vz));
    n[0] = longint'(pl_nx);
    n[1] = longint'(pl_ny);
    n[2] = longint'(pl_nz);
    r    = longint'({1'b0, q.rad});
    res  = '0;
    sdist = ((n[0]*c[0] + n[1]*c[1] + n[2]*c[2]) >>> FRAC_BITS) + longint'(pl_ofs);
    // already overlapping
    if (sdist <= r && sdist >= -r) begin
      res.hit = 1'b1;
      res.px  = q.cx;
      res.py  = q.cy;
      res.pz  = q.cz;
      return res;
    end
    denom = (n[0]*v[0] + n[1]*v[1] + n[2]*v[2]) >>> FRAC_BITS;
    if (denom == 0 || ((denom > 0) == (sdist > 0))) return res;
    s   = (sdist > 0) ? r : -r;
    num = s - sdist;
    if (num < 0) num = -num;
    den = (denom < 0) ? -denom : denom;
    quo = (num <<< FRAC_BITS) / den;
    t   = (quo > 64'sh7fff_ffff) ? 64'sh7fff_ffff : quo;
    res.hit = 1'b1;
    res.t   = t[30:0];
    for (int k = 0; k < 3; k++) begin
      p = c[k] + ((t * v[k]) >>> FRAC_BITS) - ((s * n[k]) >>> FRAC_BITS);
      if (p > 64'sh7fff_ffff) p = 64'sh7fff_ffff;
      if (p < -64'sh8000_0000) p = -64'sh8000_0000;
      if (k == 0) res.px = p[31:0];
      else if (k == 1) res.py = p[31:0];
      else res.pz = p[31:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
    n_errors++;
  endtask

  // Compare every result with the oldest prediction
  always @(posedge clk) begin
    contact_t want;
    if (rst_n && out_valid) begin
      if (contacts_due.size() == 0) begin
        report_mismatch("unexpected result", {31'd0, out_hit}, 32'd0);
      end else begin
        want = contacts_due.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", {31'd0, out_hit}, {31'd0, want.hit});
        if (out_hit_time !== want.t)
          report_mismatch("hit_time", {1'b0, out_hit_time}, {1'b0, want.t});
        if (out_contact_x !== want.px) report_mismatch("contact_x", out_contact_x, want.px);
        if (out_contact_y !== want.py) report_mismatch("contact_y", out_contact_y, want.py);
        if (out_contact_z !== want.pz) report_mismatch("contact_z", out_contact_z, want.pz);
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  // Present one query, hold it until accepted, then idle a random while
  task automatic send_query(query_t q, logic typed, contact_t exp);
    int  gap;
    bit  ready;
    start            <= 1'b1;
    in_center_x      <= q.cx;
    in_center_y      <= q.cy;
    in_center_z      <= q.cz;
    in_sphere_radius <= q.rad;
    in_move_x        <= q.vx;
    in_move_y        <= q.vy;
    in_move_z        <= q.vz;
    do begin
      @(negedge clk);
      ready = !busy;
      @(posedge clk);
    end while (!ready);
    contacts_due.push_back(typed ? exp : sweep_sphere(q));
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write one register; the caller drops the write enable after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_NX:  pl_nx  = val[NRM_W-1:0];
      REG_NY:  pl_ny  = val[NRM_W-1:0];
      REG_NZ:  pl_nz  = val[NRM_W-1:0];
      REG_OFS: pl_ofs = val;
      default: ;
    endcase
  endtask

  // Pick a normal component for a phase, upper bits left as noise
  function automatic logic [31:0] pick_normal(int ph);
    logic [31:0] val;
    case (ph)
      1:       val = ($urandom_range(0, 1) != 0) ? ONE : -ONE;
      2:       val = ($urandom_range(0, 1) != 0) ? 32'h0001_ffff : 32'hfffe_0000;
      3:       val = 32'd0;
      default: val = 32'($urandom_range(0, 131072)) - ONE;
    endcase
    return {$urandom() & 32'hfffc_0000} | (val & 32'h0003_ffff);
  endfunction

  function automatic logic [31:0] pick_word(int mode);
    case (mode)
      0:       return $urandom();
      1:       return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
      default: begin
        case ($urandom_range(0, 3))
          0:       return SMIN;
          1:       return SMAX;
          2:       return 32'd0;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // Hold until every prediction is met, then let the pipe empty
  task automatic drain_pipe();
    while (contacts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  initial begin
    query_t q;
    int     mode;
    clk              = 1'b0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_center_x      = '0;
    in_center_y      = '0;
    in_center_z      = '0;
    in_sphere_radius = '0;
    in_move_x        = '0;
    in_move_y        = '0;
    in_move_z        = '0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    n_errors         = 0;
    cycle_cnt        = 0;
    pl_nx            = '0;
    pl_ny            = ONE[NRM_W-1:0];
    pl_nz            = '0;
    pl_ofs           = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the reset plane
    for (int i = 0; i < NROWS; i++) send_query(dir_tab[i].q, dir_tab[i].typed, dir_tab[i].exp);

    // Random phases, each under a fresh plane
    for (int ph = 0; ph < PHASES; ph++) begin
      start <= 1'b0;
      drain_pipe();
      write_reg(REG_NX, pick_normal(ph));
      write_reg(REG_NY, pick_normal(ph));
      write_reg(REG_NZ, pick_normal(ph));
      case (ph)
        1:       write_reg(REG_OFS, SMIN);
        2:       write_reg(REG_OFS, SMAX);
        3:       write_reg(REG_OFS, 32'd0);
        default: write_reg(REG_OFS, pick_word($urandom_range(0, 1)));
      endcase
      cfg_we <= 1'b0;
      for (int i = 0; i < RAND_ITEMS / PHASES; i++) begin
        mode  = $urandom_range(0, 3);
        q.cx  = pick_word(mode == 3 ? 2 : (mode == 0 ? 0 : 1));
        q.cy  = pick_word(mode == 3 ? 2 : (mode == 0 ? 0 : 1));
        q.cz  = pick_word(mode == 3 ? 2 : (mode == 0 ? 0 : 1));
        q.vx  = pick_word(mode == 3 ? 2 : (mode == 0 ? 0 : 1));
        q.vy  = pick_word(mode == 3 ? 2 : (mode == 0 ? 0 : 1));
        q.vz  = pick_word(mode == 3 ? 2 : (mode == 0 ? 0 : 1));
        case (mode)
          0:       q.rad = $urandom();
          3:       q.rad = ($urandom_range(0, 1) != 0) ? RMAX : 31'd0;
          default: q.rad = 31'($urandom_range(0, 32'h0010_0000));
        endcase
        send_query(q, 1'b0, NO_HIT);
      end
    end

    start <= 1'b0;
    drain_pipe();
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
